@@ hdl/swa_pkg.sv @@
// shared constants for the sliding window average block
package swa_pkg;

  localparam int WINDOW_MAX_DEF  = 16;
  localparam int SAMPLE_BITS_DEF = 16;
  localparam int QUEUE_DEPTH     = 2;

endpackage

@@ hdl/sliding_window_average_top.sv @@
// sliding window average: top level joining front, request queue and back
//
// channel  direction  handshake                fields
// in_      input      in_push / in_full        in_sample
// out_     output     out_empty / out_pop      out_average, out_samples_held
// cfg_     input      cfg_we                   cfg_window_length
//
// in the back part each request passes through the states IDLE, LOAD, DIV and DONE,
// and in DIV the restoring divider yields one quotient bit per cycle
// while the two-entry queue is not full, the front tags requests into it at one per cycle as the back works
// reset (rst_n low, synchronous) sets window length to WINDOW_MAX and empties the window
// a stalled out_pop holds the back in its final state; the queue then fills and raises in_full
module sliding_window_average_top
  import swa_pkg::*;
#(
  parameter int WINDOW_MAX  = WINDOW_MAX_DEF,
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_we,
  input  logic [$clog2(WINDOW_MAX+1)-1:0]    cfg_window_length,
  input  logic                               in_push,
  input  logic signed [SAMPLE_BITS-1:0]      in_sample,
  output logic                               in_full,
  output logic signed [SAMPLE_BITS-1:0]      out_average,
  output logic [$clog2(WINDOW_MAX+1)-1:0]    out_samples_held,
  output logic                               out_empty,
  input  logic                               out_pop
);

  localparam int COUNT_BITS = $clog2(WINDOW_MAX+1);
  localparam int PTR_BITS   = $clog2(WINDOW_MAX);
  localparam int SUM_BITS   = SAMPLE_BITS + $clog2(WINDOW_MAX);
  localparam int ENTRY_BITS = SAMPLE_BITS + PTR_BITS + 1 + COUNT_BITS;

  logic                  q_push, q_full, q_pop, q_empty;
  logic [ENTRY_BITS-1:0] q_din, q_dout;

  swa_front #(
    .WINDOW_MAX  (WINDOW_MAX),
    .SAMPLE_BITS (SAMPLE_BITS),
    .COUNT_BITS  (COUNT_BITS),
    .PTR_BITS    (PTR_BITS),
    .ENTRY_BITS  (ENTRY_BITS)
  ) u_front (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_window_length (cfg_window_length),
    .in_push           (in_push),
    .in_sample         (in_sample),
    .in_full           (in_full),
    .q_push            (q_push),
    .q_entry           (q_din),
    .q_full            (q_full)
  );

  swa_fifo #(
    .WIDTH (ENTRY_BITS),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .din   (q_din),
    .full  (q_full),
    .pop   (q_pop),
    .dout  (q_dout),
    .empty (q_empty)
  );

  swa_back #(
    .WINDOW_MAX  (WINDOW_MAX),
    .SAMPLE_BITS (SAMPLE_BITS),
    .COUNT_BITS  (COUNT_BITS),
    .PTR_BITS    (PTR_BITS),
    .SUM_BITS    (SUM_BITS),
    .ENTRY_BITS  (ENTRY_BITS)
  ) u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .q_entry          (q_dout),
    .q_empty          (q_empty),
    .q_pop            (q_pop),
    .out_average      (out_average),
    .out_samples_held (out_samples_held),
    .out_empty        (out_empty),
    .out_pop          (out_pop)
  );

  a_held_range: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty |-> (out_samples_held != '0) &&
                   (out_samples_held <= COUNT_BITS'(WINDOW_MAX)))
    else $error("held count out of range");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> !q_empty)
    else $error("back took a request from an empty queue");

  a_result_drain: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_empty) |-> $past(out_pop))
    else $error("result dropped without pop");

endmodule

@@ hdl/swa_ram.sv @@
// generic single write, single read RAM with registered read data
module swa_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

@@ hdl/swa_fifo.sv @@
// small register queue between the front and back parts
module swa_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] din,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] dout,
  output logic             empty
);

  localparam int PB = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PB-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [PB-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [PB:0]      count_r, count_nxt;
  logic             do_push, do_pop;

  assign full    = (count_r == (PB+1)'(DEPTH));
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign dout    = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PB'(DEPTH-1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PB'(DEPTH-1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= din;
    end
  end

endmodule

@@ hdl/swa_front.sv @@
// front part: takes samples, tracks window length, fill and slot, tags each request
module swa_front #(
  parameter int WINDOW_MAX  = 16,
  parameter int SAMPLE_BITS = 16,
  parameter int COUNT_BITS  = 5,
  parameter int PTR_BITS    = 4,
  parameter int ENTRY_BITS  = 26
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_we,
  input  logic [COUNT_BITS-1:0]        cfg_window_length,
  input  logic                         in_push,
  input  logic signed [SAMPLE_BITS-1:0] in_sample,
  output logic                         in_full,
  output logic                         q_push,
  output logic [ENTRY_BITS-1:0]        q_entry,
  input  logic                         q_full
);

  logic [COUNT_BITS-1:0] len_r, len_nxt;
  logic [COUNT_BITS-1:0] fill_r, fill_nxt;
  logic [PTR_BITS-1:0]   ptr_r, ptr_nxt;
  logic                  evict;
  logic                  accept;

  assign in_full = q_full;
  assign accept  = in_push && !q_full;
  assign q_push  = accept;
  assign evict   = (fill_r >= len_r);

  // sample, slot, evict flag, held count after this append
  assign q_entry = {in_sample, ptr_r, evict, fill_nxt};

  always_comb begin
    len_nxt  = len_r;
    fill_nxt = evict ? fill_r : fill_r + 1'b1;
    ptr_nxt  = ptr_r;
    if (cfg_window_length == '0) begin
      len_nxt = COUNT_BITS'(1);
    end else if (cfg_window_length > COUNT_BITS'(WINDOW_MAX)) begin
      len_nxt = COUNT_BITS'(WINDOW_MAX);
    end else begin
      len_nxt = cfg_window_length;
    end
    if ((COUNT_BITS'(ptr_r) + 1'b1) == len_r) begin
      ptr_nxt = '0;
    end else begin
      ptr_nxt = ptr_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r  <= COUNT_BITS'(WINDOW_MAX);
      fill_r <= '0;
      ptr_r  <= '0;
    end else if (cfg_we) begin
      len_r  <= len_nxt;
      fill_r <= '0;
      ptr_r  <= '0;
    end else if (accept) begin
      fill_r <= fill_nxt;
      ptr_r  <= ptr_nxt;
    end
  end

endmodule

@@ hdl/swa_back.sv @@
// back part: updates the running sum through the store and divides by the held count
module swa_back #(
  parameter int WINDOW_MAX  = 16,
  parameter int SAMPLE_BITS = 16,
  parameter int COUNT_BITS  = 5,
  parameter int PTR_BITS    = 4,
  parameter int SUM_BITS    = 20,
  parameter int ENTRY_BITS  = 26
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [ENTRY_BITS-1:0]         q_entry,
  input  logic                          q_empty,
  output logic                          q_pop,
  output logic signed [SAMPLE_BITS-1:0] out_average,
  output logic [COUNT_BITS-1:0]         out_samples_held,
  output logic                          out_empty,
  input  logic                          out_pop
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_LOAD = 2'd1;
  localparam logic [1:0] ST_DIV  = 2'd2;
  localparam logic [1:0] ST_DONE = 2'd3;
  localparam int STEP_BITS = $clog2(SUM_BITS);

  logic [1:0]                    state_r, state_nxt;
  logic signed [SAMPLE_BITS-1:0] sample_r;
  logic [PTR_BITS-1:0]           slot_r;
  logic                          evict_r;
  logic [COUNT_BITS-1:0]         count_r;
  logic signed [SUM_BITS-1:0]    sum_r, sum_nxt;
  logic [SUM_BITS-1:0]           quo_r, quo_nxt;
  logic [COUNT_BITS-1:0]         rem_r, rem_nxt;
  logic                          neg_r;
  logic [STEP_BITS-1:0]          step_r;
  logic                          out_valid_r;
  logic signed [SAMPLE_BITS-1:0] avg_r;
  logic [COUNT_BITS-1:0]         held_r;

  logic signed [SAMPLE_BITS-1:0] e_sample;
  logic [PTR_BITS-1:0]           e_slot;
  logic                          e_evict;
  logic [COUNT_BITS-1:0]         e_count;
  logic [SAMPLE_BITS-1:0]        old_raw;
  logic signed [SUM_BITS-1:0]    old_ext, new_ext;
  logic [SUM_BITS-1:0]           sum_mag;
  logic [COUNT_BITS:0]           rem_shift;
  logic                          ge;
  logic [SUM_BITS-1:0]           quo_signed;
  logic                          out_free;

  assign {e_sample, e_slot, e_evict, e_count} = q_entry;
  assign q_pop     = (state_r == ST_IDLE) && !q_empty;
  assign out_free  = !out_valid_r || out_pop;
  assign out_empty = !out_valid_r;
  assign out_average      = avg_r;
  assign out_samples_held = held_r;

  swa_ram #(
    .WIDTH (SAMPLE_BITS),
    .DEPTH (WINDOW_MAX)
  ) u_store (
    .clk   (clk),
    .we    (state_r == ST_LOAD),
    .waddr (slot_r),
    .wdata (sample_r),
    .raddr (e_slot),
    .rdata (old_raw)
  );

  always_comb begin
    old_ext = evict_r ? SUM_BITS'(signed'(old_raw)) : '0;
    new_ext = SUM_BITS'(sample_r);
    sum_nxt = sum_r - old_ext + new_ext;
    sum_mag = sum_nxt[SUM_BITS-1] ? (~sum_nxt + 1'b1) : sum_nxt;
    // restoring division, one quotient bit per cycle
    rem_shift = {rem_r, quo_r[SUM_BITS-1]};
    ge        = (rem_shift >= {1'b0, count_r});
    rem_nxt   = ge ? COUNT_BITS'(rem_shift - {1'b0, count_r}) : rem_shift[COUNT_BITS-1:0];
    quo_nxt   = {quo_r[SUM_BITS-2:0], ge};
    quo_signed = neg_r ? (~quo_r + 1'b1) : quo_r;
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (!q_empty) begin
          state_nxt = ST_LOAD;
        end
      end
      ST_LOAD: state_nxt = ST_DIV;
      ST_DIV: begin
        if (step_r == '0) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      sum_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        sum_r <= '0;
      end else if (state_r == ST_LOAD) begin
        sum_r <= sum_nxt;
      end
      if (state_r == ST_DONE && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_pop) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      ST_IDLE: begin
        sample_r <= e_sample;
        slot_r   <= e_slot;
        evict_r  <= e_evict;
        count_r  <= e_count;
      end
      ST_LOAD: begin
        quo_r  <= sum_mag;
        rem_r  <= '0;
        neg_r  <= sum_nxt[SUM_BITS-1];
        step_r <= STEP_BITS'(SUM_BITS-1);
      end
      ST_DIV: begin
        quo_r  <= quo_nxt;
        rem_r  <= rem_nxt;
        step_r <= step_r - 1'b1;
      end
      ST_DONE: begin
        if (out_free) begin
          avg_r  <= signed'(quo_signed[SAMPLE_BITS-1:0]);
          held_r <= count_r;
        end
      end
      default: begin
        step_r <= '0;
      end
    endcase
  end

endmodule
